// ===== rtl/fir_filter_core_assert.svh =====
// Assertion macros shared by the FIR filter RTL
`ifndef FIR_FILTER_CORE_ASSERT_SVH
`define FIR_FILTER_CORE_ASSERT_SVH

// Check a property on every rising clock edge outside reset
`define FIR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a consequence in the following cycle
`define FIR_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

// ===== rtl/fir_pkg.sv =====
// Package with constants, types and codes of the FIR filter
package fir_pkg;

   // Number of taps built into the cell row
   localparam int TAPS = 256;

   // Field widths
   localparam int SAMPLE_W = 16;
   localparam int COEF_W   = 18;
   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 9;
   localparam int PROD_W   = SAMPLE_W + COEF_W;
   localparam int ACC_W    = 46;

   // Tap counter and compare widths
   localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   // Reset value of the tap count register
   localparam logic [COUNT_W-1:0] TAP_COUNT_RESET = COUNT_W'(256);

   // Operation codes of an input beat
   typedef enum logic {
      OP_FILTER = 1'b0,
      OP_COEF   = 1'b1
   } fir_op_type;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN,
      ST_DONE
   } fir_state_type;

   // Control broadcast to every cell of the row
   typedef struct packed {
      logic shift;
      logic rotate;
   } fir_cell_ctrl_type;

   // Control of the multiply-accumulate unit
   typedef struct packed {
      logic clear;
      logic take;
   } fir_mac_ctrl_type;

endpackage

// ===== rtl/fir_cell.sv =====
// One tap cell: holds one history sample and one coefficient
module fir_cell
   import fir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  fir_cell_ctrl_type          ctrl,
   input  logic                       load,
   input  logic signed [SAMPLE_W-1:0] hist_prev,
   input  logic signed [SAMPLE_W-1:0] hist_next,
   input  logic signed [COEF_W-1:0]   coef_next,
   input  logic signed [COEF_W-1:0]   coef_wdata,
   output logic signed [SAMPLE_W-1:0] hist_q,
   output logic signed [COEF_W-1:0]   coef_q
);

   logic signed [SAMPLE_W-1:0] hist_ff;
   logic signed [SAMPLE_W-1:0] hist_in;
   logic signed [COEF_W-1:0]   coef_ff;
   logic signed [COEF_W-1:0]   coef_in;

   // Shift a new sample in, or rotate the ring towards the head
   always_comb begin
      priority if (ctrl.shift) begin
         hist_in = hist_prev;
      end else if (ctrl.rotate) begin
         hist_in = hist_next;
      end else begin
         hist_in = hist_ff;
      end
   end

   // Rotate coefficients with the history, or take a write
   always_comb begin
      priority if (ctrl.rotate) begin
         coef_in = coef_next;
      end else if (load) begin
         coef_in = coef_wdata;
      end else begin
         coef_in = coef_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff <= '0;
         coef_ff <= '0;
      end else begin
         hist_ff <= hist_in;
         coef_ff <= coef_in;
      end
   end

   assign hist_q = hist_ff;
   assign coef_q = coef_ff;

endmodule

// ===== rtl/fir_mac.sv =====
// Multiply-accumulate unit at the head of the cell ring
module fir_mac
   import fir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  fir_mac_ctrl_type           ctrl,
   input  logic signed [SAMPLE_W-1:0] hist,
   input  logic signed [COEF_W-1:0]   coef,
   output logic signed [ACC_W-1:0]    acc
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_vld_ff;
   logic                     prod_vld_in;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   // Register the product of the head tap
   always_comb begin
      prod_in     = hist * coef;
      prod_vld_in = ctrl.take;
   end

   // Clear at the start of a sample, else add the registered product
   always_comb begin
      priority if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= prod_vld_in & ~ctrl.clear;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/fir_filter_core.sv =====
// Direct-form FIR filter: ring of tap cells feeding one multiply-accumulate unit
//
// A sample beat is shifted into the history row of TAPS cells (256), then both
// the history and the coefficient rings rotate one cell per cycle past a single
// 16x18 multiply-accumulate unit at the head. The sample then passes the run,
// drain and done states before its 46-bit result is offered on rsp_, and the
// next beat is accepted once the sequencer is back in idle. Only the first
// tap_count taps are summed (tap_count above TAPS counts as TAPS, zero gives a
// zero result). A coefficient beat writes one cell and gives no result; the
// 8-bit index always names a cell. The result register lets a finished result
// wait while the next beat is taken. History and coefficients are cleared by
// reset, with no clearing pass.
module fir_filter_core
   import fir_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // input beats
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic                       req_operation,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic [INDEX_W-1:0]         req_coef_index,
   input  logic signed [COEF_W-1:0]   req_coef_value,
   // result beats
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [ACC_W-1:0]    rsp_filtered,
   // tap count register
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [COUNT_W-1:0]         csr_tap_count
);

   fir_state_type              state_ff;
   fir_state_type              state_in;
   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           cnt_in;
   logic [COUNT_W-1:0]         tap_count_ff;
   logic                       rsp_valid_ff;
   logic signed [ACC_W-1:0]    rsp_filtered_ff;

   fir_cell_ctrl_type          cell_ctrl;
   fir_mac_ctrl_type           mac_ctrl;
   logic                       coef_wen;
   logic                       rsp_load;
   logic                       cnt_last;
   logic                       tap_used;
   logic                       filter_beat;
   logic                       coef_beat;

   logic signed [SAMPLE_W-1:0] hist_q [TAPS];
   logic signed [COEF_W-1:0]   coef_q [TAPS];
   logic signed [ACC_W-1:0]    acc;

   // Decode the input beat
   assign filter_beat = req_valid && (fir_op_type'(req_operation) == OP_FILTER);
   assign coef_beat   = req_valid && (fir_op_type'(req_operation) == OP_COEF);

   assign cnt_last = (cnt_ff == CNT_W'(TAPS - 1));
   assign tap_used = (CMP_W'(cnt_ff) < CMP_W'(tap_count_ff));

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (filter_beat) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (cnt_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_stall        = 1'b1;
      csr_ready        = 1'b0;
      cell_ctrl.shift  = 1'b0;
      cell_ctrl.rotate = 1'b0;
      coef_wen         = 1'b0;
      mac_ctrl.clear   = 1'b0;
      mac_ctrl.take    = 1'b0;
      rsp_load         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall       = 1'b0;
            csr_ready       = 1'b1;
            cell_ctrl.shift = filter_beat;
            mac_ctrl.clear  = filter_beat;
            coef_wen        = coef_beat;
         end
         ST_RUN: begin
            cell_ctrl.rotate = 1'b1;
            mac_ctrl.take    = tap_used;
         end
         ST_DRAIN: begin
         end
         ST_DONE: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
         end
      endcase
   end

   // Count taps while the ring rotates
   always_comb begin
      cnt_in = cnt_ff;
      if (cell_ctrl.shift || (cell_ctrl.rotate && cnt_last)) begin
         cnt_in = '0;
      end else if (cell_ctrl.rotate) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // Hold the tap count register
   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff <= TAP_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         tap_count_ff <= csr_tap_count;
      end
   end

   // Row of tap cells: shift towards the tail, rotate towards the head
   for (genvar k = 0; k < TAPS; k++) begin : g_cell
      logic signed [SAMPLE_W-1:0] hist_prev;
      logic                       load;

      if (k == 0) begin : g_head
         assign hist_prev = req_sample;
      end else begin : g_body
         assign hist_prev = hist_q[k-1];
      end

      assign load = coef_wen && (32'(req_coef_index) == 32'(k));

      fir_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .load       (load),
         .hist_prev  (hist_prev),
         .hist_next  (hist_q[(k + 1) % TAPS]),
         .coef_next  (coef_q[(k + 1) % TAPS]),
         .coef_wdata (req_coef_value),
         .hist_q     (hist_q[k]),
         .coef_q     (coef_q[k])
      );
   end

   fir_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (mac_ctrl),
      .hist  (hist_q[0]),
      .coef  (coef_q[0]),
      .acc   (acc)
   );

   // Result register: load a finished sum, drop the beat once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_filtered_ff <= acc;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   `include "fir_filter_core_assert.svh"

   // A sample beat reaches the result stage after a full ring turn and the drain state
   `FIR_ASSERT_NEXT(a_sample_done, req_valid && !req_stall && !req_operation, ##(TAPS + 1) (state_ff == ST_DONE), "sample did not finish after a full ring turn")

   // A coefficient beat gives no result and leaves the block idle
   `FIR_ASSERT_NEXT(a_coef_idle, req_valid && !req_stall && req_operation, state_ff == ST_IDLE, "coefficient beat left the idle state")

   // A waiting result is never overwritten
   `FIR_ASSERT_NEXT(a_no_overwrite, state_ff == ST_DONE && rsp_valid_ff && rsp_stall, state_ff == ST_DONE, "finished sum left while result register full")

   // The ring never shifts and rotates together
   `FIR_ASSERT(a_rotate_run, !cell_ctrl.rotate || !cell_ctrl.shift, "ring shifted and rotated together")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the direct-form FIR filter core
`timescale 1ns / 1ps

module tb;
   import fir_pkg::*;

   // Run limits and timing
   localparam int          RESET_CYCLES   = 11;
   localparam int          DRAIN_CYCLES   = TAPS + 16;
   localparam int          HOLDOFF_CYCLES = 3000;
   localparam int unsigned CYCLE_LIMIT    = 3_000_000;

   // Field extremes
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic signed [COEF_W-1:0]   COEF_MIN   = {1'b1, {(COEF_W-1){1'b0}}};
   localparam logic signed [COEF_W-1:0]   COEF_MAX   = {1'b0, {(COEF_W-1){1'b1}}};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic                       req_operation = OP_FILTER;
   logic signed [SAMPLE_W-1:0] req_sample = '0;
   logic [INDEX_W-1:0]         req_coef_index = '0;
   logic signed [COEF_W-1:0]   req_coef_value = '0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [ACC_W-1:0]    rsp_filtered;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [COUNT_W-1:0]         csr_tap_count = '0;

   // Filter state mirrored by the testbench
   logic signed [SAMPLE_W-1:0] sample_line [TAPS];
   logic signed [COEF_W-1:0]   coef_bank [TAPS];
   logic [COUNT_W-1:0]         tap_limit;
   logic signed [ACC_W-1:0]    expected_filtered [$];

   int          fail_count = 0;
   int unsigned cycle_count = 0;
   int unsigned burst_left = 0;
   int unsigned holdoff_request = 0;

   fir_filter_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_operation  (req_operation),
      .req_sample     (req_sample),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_filtered   (rsp_filtered),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_tap_count  (csr_tap_count)
   );

   // Free-running clock
   initial begin
      forever #1 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("fir_filter_core verification failed");
         $finish;
      end
   end

   // Shift a sample into the line and sum the products of the taps in use
   function automatic logic signed [ACC_W-1:0] filter_sample(logic signed [SAMPLE_W-1:0] s);
      longint acc;
      int     n;
      for (int k = TAPS - 1; k > 0; k--)
         sample_line[k] = sample_line[k-1];
      sample_line[0] = s;
      n = (int'(tap_limit) > TAPS) ? TAPS : int'(tap_limit);
      acc = 0;
      for (int k = 0; k < n; k++)
         acc += longint'(coef_bank[k]) * longint'(sample_line[k]);
      return acc[ACC_W-1:0];
   endfunction

   // Track register writes and accepted input beats
   always @(posedge clock) begin
      if (reset) begin
         foreach (sample_line[k]) sample_line[k] = '0;
         foreach (coef_bank[k]) coef_bank[k] = '0;
         tap_limit = TAP_COUNT_RESET;
      end else begin
         if (csr_valid && csr_ready === 1'b1)
            tap_limit = csr_tap_count;
         if (req_valid && req_stall === 1'b0) begin
            if (req_operation == OP_COEF) begin
               if (int'(req_coef_index) < TAPS)
                  coef_bank[req_coef_index] = req_coef_value;
            end else begin
               expected_filtered.push_back(filter_sample(req_sample));
            end
         end
      end
   end

   // Compare each result beat with the oldest pending sum
   always @(posedge clock) begin : check_result
      logic signed [ACC_W-1:0] want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
         if (expected_filtered.size() == 0) begin
            $error("filtered: expected nothing, actual %0d", rsp_filtered);
            fail_count++;
         end else begin
            want = expected_filtered.pop_front();
            if (rsp_filtered !== want) begin
               $error("filtered: expected %0d, actual %0d", want, rsp_filtered);
               fail_count++;
            end
         end
      end
   end

   // Stall results at a rate that changes from stretch to stretch; honour hold-off requests
   initial begin : rsp_stall_pattern
      int unsigned stall_pct;
      int unsigned mode_left;
      int unsigned hold_left;
      stall_pct = 0;
      mode_left = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (holdoff_request != 0) begin
            hold_left = holdoff_request;
            holdoff_request = 0;
         end
         if (mode_left == 0) begin
            mode_left = $urandom_range(50, 1500);
            case ($urandom_range(3))
               0: stall_pct = 0;
               1: stall_pct = 20;
               2: stall_pct = 50;
               default: stall_pct = 85;
            endcase
         end
         mode_left--;
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
         end
      end
   end

   // Offer one input beat, opening a new burst after a random gap, and hold until taken
   task automatic offer_beat(fir_op_type op, logic signed [SAMPLE_W-1:0] s,
                             logic [INDEX_W-1:0] idx, logic signed [COEF_W-1:0] val);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap = ($urandom_range(15) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_sample     <= s;
      req_coef_index <= idx;
      req_coef_value <= val;
      do @(posedge clock); while (!(req_valid && req_stall === 1'b0));
   endtask

   task automatic send_sample(logic signed [SAMPLE_W-1:0] s);
      offer_beat(OP_FILTER, s, INDEX_W'($urandom), COEF_W'($urandom));
   endtask

   task automatic load_coef(logic [INDEX_W-1:0] idx, logic signed [COEF_W-1:0] val);
      offer_beat(OP_COEF, SAMPLE_W'($urandom), idx, val);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] random_sample();
      case ($urandom_range(15))
         0: return SAMPLE_MIN;
         1: return SAMPLE_MAX;
         2: return '0;
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   function automatic logic signed [COEF_W-1:0] random_coef();
      case ($urandom_range(15))
         0: return COEF_MIN;
         1: return COEF_MAX;
         2: return '0;
         default: return COEF_W'($urandom);
      endcase
   endfunction

   // Drop valid, wait for every pending sum, then let a coefficient beat settle
   task automatic settle_block();
      req_valid <= 1'b0;
      while (expected_filtered.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Write the tap count once the block is idle
   task automatic set_tap_count(logic [COUNT_W-1:0] taps);
      settle_block();
      csr_valid     <= 1'b1;
      csr_tap_count <= taps;
      do @(posedge clock); while (!(csr_valid && csr_ready === 1'b1));
      csr_valid <= 1'b0;
   endtask

   // Zero coefficients after reset give zero sums at the default tap count
   task automatic test_reset_defaults();
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
   endtask

   // Extreme coefficients at both ends of the store, extreme samples
   task automatic test_coef_extremes();
      load_coef(8'd0, COEF_MIN);
      load_coef(8'd1, COEF_MAX);
      load_coef(8'd2, 18'sd1);
      load_coef(8'd3, -18'sd1);
      load_coef(8'd255, COEF_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(SAMPLE_MAX);
      send_sample(16'sh5A5A);
   endtask

   // Zero taps give zero; counts above the row saturate
   task automatic test_tap_count_limits();
      set_tap_count(9'd0);
      send_sample(SAMPLE_MAX);
      set_tap_count(9'd511);
      send_sample(SAMPLE_MIN);
      set_tap_count(9'd257);
      send_sample(16'sd1234);
      set_tap_count(9'd1);
      send_sample(-16'sd4321);
   endtask

   // Samples keep shifting while few taps are used, and count once more taps are on
   task automatic test_history_span();
      send_sample(16'sd100);
      send_sample(-16'sd200);
      send_sample(16'sd300);
      set_tap_count(9'd256);
      send_sample(16'sd7);
   endtask

   // Phases of random traffic: load coefficients, then stream samples with stray writes
   task automatic test_random_traffic();
      logic [COUNT_W-1:0] taps;
      int unsigned        n_coef;
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: taps = 9'd256;
            1: taps = 9'd511;
            2: taps = 9'd1;
            3: taps = COUNT_W'($urandom_range(2, 255));
            4: taps = 9'd0;
            5: taps = 9'd257;
            6: taps = 9'd255;
            default: taps = COUNT_W'($urandom_range(0, 511));
         endcase
         set_tap_count(taps);
         n_coef = $urandom_range(4, 40);
         repeat (n_coef) load_coef(INDEX_W'($urandom), random_coef());
         repeat (100 - n_coef) begin
            if ($urandom_range(19) == 0)
               load_coef(INDEX_W'($urandom), random_coef());
            else
               send_sample(random_sample());
         end
      end
   endtask

   // Hold results off long enough for the block to fill and stall its input
   task automatic test_backpressure();
      holdoff_request = HOLDOFF_CYCLES;
      repeat (20) begin
         if ($urandom_range(4) == 0)
            load_coef(INDEX_W'($urandom), random_coef());
         else
            send_sample(random_sample());
      end
   endtask

   // Reset, run each test in turn, report
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_coef_extremes();
      test_tap_count_limits();
      test_history_span();
      test_random_traffic();
      test_backpressure();
      settle_block();
      if (fail_count == 0)
         $display("fir_filter_core verification clean");
      else
         $display("fir_filter_core verification failed");
      $finish;
   end

endmodule
